[rtl/core/rgb_to_hsv_pixel_macros.svh]
// ---------------------------------------------------------------------------
// RGB to HSV pixel converter: assertion macros
// Shorthands for the concurrent checks in the converter's RTL. Each macro
// samples on clk_i and is disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef RGB_TO_HSV_PIXEL_MACROS_SVH
`define RGB_TO_HSV_PIXEL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RHP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RHP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rgbhsv_pkg.sv]
// ---------------------------------------------------------------------------
// RGB to HSV pixel converter: shared package
// Item types, scaling constants and the record that travels along the chain
// of divider cells.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rgbhsv_pkg;

  // Scaling constants of the hue circle and the saturation range.
  localparam int unsigned HueSextant  = 43;
  localparam int unsigned HueOfsRed   = 0;
  localparam int unsigned HueOfsGreen = 85;
  localparam int unsigned HueOfsBlue  = 171;
  localparam int unsigned FullScale   = 255;

  // One divider cell per quotient bit; both quotients stay below 256.
  localparam int unsigned QuotBits = 8;
  localparam int unsigned RemBits  = 16;

  // Input item.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_rgb_t;

  // Result item.
  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } pixel_hsv_t;

  // Record handed from cell to cell: two restoring divisions side by side.
  typedef struct packed {
    logic [RemBits-1:0]  sat_rem;
    logic [7:0]          sat_div;
    logic [QuotBits-1:0] sat_q;
    logic [RemBits-1:0]  hue_rem;
    logic [7:0]          hue_div;
    logic [QuotBits-1:0] hue_q;
    logic                hue_neg;
    logic [7:0]          hue_base;
    logic                grey;
    logic [7:0]          brightness;
  } rgbhsv_stage_t;

endpackage

`default_nettype wire

[rtl/core/rgbhsv_prep.sv]
// ---------------------------------------------------------------------------
// RGB to HSV pixel converter: front stage
// Finds the channel extremes, picks the hue sextant and forms the two
// dividends and divisors that the divider cells work on.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbhsv_prep (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  rgbhsv_pkg::pixel_rgb_t     pixel_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output rgbhsv_pkg::rgbhsv_stage_t  stage_o
);

  logic                      valid_q;
  rgbhsv_pkg::rgbhsv_stage_t stage_q;
  rgbhsv_pkg::rgbhsv_stage_t stage_d;

  logic [7:0] max_val;
  logic [7:0] min_val;
  logic [7:0] chroma;
  logic [7:0] op_a;
  logic [7:0] op_b;
  logic [8:0] diff;
  logic [8:0] diff_abs;
  logic [13:0] hue_num;

  // Channel extremes; red takes ties over green, green over blue.
  always_comb begin
    max_val = pixel_i.red;
    min_val = pixel_i.red;
    if (pixel_i.green > max_val) max_val = pixel_i.green;
    if (pixel_i.blue > max_val) max_val = pixel_i.blue;
    if (pixel_i.green < min_val) min_val = pixel_i.green;
    if (pixel_i.blue < min_val) min_val = pixel_i.blue;
  end

  assign chroma = max_val - min_val;

  // Sextant selection and the signed channel difference.
  always_comb begin
    stage_d = '0;
    if (max_val == pixel_i.red) begin
      op_a              = pixel_i.green;
      op_b              = pixel_i.blue;
      stage_d.hue_base  = 8'(rgbhsv_pkg::HueOfsRed);
    end else if (max_val == pixel_i.green) begin
      op_a              = pixel_i.blue;
      op_b              = pixel_i.red;
      stage_d.hue_base  = 8'(rgbhsv_pkg::HueOfsGreen);
    end else begin
      op_a              = pixel_i.red;
      op_b              = pixel_i.green;
      stage_d.hue_base  = 8'(rgbhsv_pkg::HueOfsBlue);
    end
    diff     = {1'b0, op_a} - {1'b0, op_b};
    diff_abs = diff[8] ? (9'd0 - diff) : diff;
    hue_num  = 14'(diff_abs[7:0]) * 14'(rgbhsv_pkg::HueSextant);

    // Saturation dividend is 255 * chroma, written as a shift and subtract.
    stage_d.sat_rem    = {chroma, 8'd0} - {8'd0, chroma};
    stage_d.sat_div    = max_val;
    stage_d.hue_rem    = rgbhsv_pkg::RemBits'(hue_num);
    stage_d.hue_div    = chroma;
    stage_d.hue_neg    = diff[8];
    stage_d.grey       = (chroma == 8'd0);
    stage_d.brightness = max_val;
  end

  // Elastic stage register.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

[rtl/core/rgbhsv_div_cell.sv]
// ---------------------------------------------------------------------------
// RGB to HSV pixel converter: divider cell
// Settles one quotient bit of both the saturation and the hue division by a
// restoring trial subtract, then hands the record to the next cell.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_to_hsv_pixel_macros.svh"

module rgbhsv_div_cell #(
  parameter int unsigned BitIdx = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  rgbhsv_pkg::rgbhsv_stage_t  stage_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output rgbhsv_pkg::rgbhsv_stage_t  stage_o
);

  localparam int unsigned TrialBits = rgbhsv_pkg::RemBits + 1;

  logic                      valid_q;
  rgbhsv_pkg::rgbhsv_stage_t stage_q;
  rgbhsv_pkg::rgbhsv_stage_t stage_d;

  logic [TrialBits-1:0] sat_shift;
  logic [TrialBits-1:0] sat_trial;
  logic [TrialBits-1:0] hue_shift;
  logic [TrialBits-1:0] hue_trial;

  logic stalled;
  logic rem_ok;

  // Divisors aligned to this cell's quotient bit.
  assign sat_shift = TrialBits'(stage_i.sat_div) << BitIdx;
  assign hue_shift = TrialBits'(stage_i.hue_div) << BitIdx;
  assign sat_trial = {1'b0, stage_i.sat_rem} - sat_shift;
  assign hue_trial = {1'b0, stage_i.hue_rem} - hue_shift;

  // Keep the difference and set the quotient bit when it did not go negative.
  always_comb begin
    stage_d = stage_i;
    if (!sat_trial[TrialBits-1]) begin
      stage_d.sat_rem       = sat_trial[TrialBits-2:0];
      stage_d.sat_q[BitIdx] = 1'b1;
    end
    if (!hue_trial[TrialBits-1]) begin
      stage_d.hue_rem       = hue_trial[TrialBits-2:0];
      stage_d.hue_q[BitIdx] = 1'b1;
    end
  end

  // Elastic stage register.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

  // Conditions used by the checks below.
  assign stalled = valid_q && !ready_i;
  assign rem_ok  = ({1'b0, stage_q.sat_rem} < (TrialBits'(stage_q.sat_div) << BitIdx)) &&
                   ({1'b0, stage_q.hue_rem} < (TrialBits'(stage_q.hue_div) << BitIdx));

  // A held record must not move while the next cell is full.
  `RHP_ASSERT_NXT(a_cell_hold, stalled, valid_q && $stable(stage_q), "cell record moved in stall")

  // After this bit both remainders are below the aligned divisor.
  `RHP_ASSERT_IMP(a_cell_rem, valid_q && !stage_q.grey, rem_ok, "remainder not reduced")

endmodule

`default_nettype wire

[rtl/core/rgbhsv_fin.sv]
// ---------------------------------------------------------------------------
// RGB to HSV pixel converter: output stage
// Applies the hue sign and sextant offset, clears grey pixels and holds the
// result item until it is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbhsv_fin (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  rgbhsv_pkg::rgbhsv_stage_t  stage_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output rgbhsv_pkg::pixel_hsv_t     pixel_o
);

  logic                   valid_q;
  rgbhsv_pkg::pixel_hsv_t pixel_q;
  rgbhsv_pkg::pixel_hsv_t pixel_d;
  logic [7:0]             hue_step;

  // Signed hue step added to the sextant offset, wrapping modulo 256.
  assign hue_step = stage_i.hue_neg ? (8'd0 - stage_i.hue_q) : stage_i.hue_q;

  always_comb begin
    pixel_d.brightness = stage_i.brightness;
    if (stage_i.grey) begin
      pixel_d.hue        = 8'd0;
      pixel_d.saturation = 8'd0;
    end else begin
      pixel_d.hue        = stage_i.hue_base + hue_step;
      pixel_d.saturation = stage_i.sat_q;
    end
  end

  // Output register.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      pixel_q <= pixel_d;
    end
  end

  assign valid_o = valid_q;
  assign pixel_o = pixel_q;

endmodule

`default_nettype wire

[rtl/core/rgb_to_hsv_pixel.sv]
// ---------------------------------------------------------------------------
// RGB to HSV pixel converter
// Converts 8-bit RGB pixels to 8-bit HSV through a chain of divider cells.
//
//   Channel   Handshake                    Payload
//   input     in_valid_i / in_ready_o      in_pixel_i  (blue, green, red)
//   output    out_valid_o / out_ready_i    out_pixel_o (hue, saturation, brightness)
//
// One item is taken per cycle while the output is not stalled; each item passes
// the front stage, eight divider cells, one per quotient bit, and the output register.
// Reset clears the valid bit of every stage; no data register is reset.
// A stall at the output fills the chain from the back; each stage still takes
// an item while the stage after it is empty or moving.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_to_hsv_pixel_macros.svh"

module rgb_to_hsv_pixel (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  rgbhsv_pkg::pixel_rgb_t  in_pixel_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output rgbhsv_pkg::pixel_hsv_t  out_pixel_o
);

  localparam int unsigned Cells = rgbhsv_pkg::QuotBits;

  logic                      valid [Cells+1];
  logic                      ready [Cells+1];
  rgbhsv_pkg::rgbhsv_stage_t stage [Cells+1];

  logic out_black;
  logic out_sat_zero;
  logic out_hue_zero;

  // Front stage: extremes, sextant and dividends.
  rgbhsv_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .pixel_i (in_pixel_i),
    .valid_o (valid[0]),
    .ready_i (ready[0]),
    .stage_o (stage[0])
  );

  // Divider cells, most significant quotient bit first.
  for (genvar k = 0; k < Cells; k++) begin : g_cell
    rgbhsv_div_cell #(
      .BitIdx (Cells - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[k]),
      .ready_o (ready[k]),
      .stage_i (stage[k]),
      .valid_o (valid[k+1]),
      .ready_i (ready[k+1]),
      .stage_o (stage[k+1])
    );
  end

  // Output stage: hue sign and offset, grey handling, result register.
  rgbhsv_fin u_fin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid[Cells]),
    .ready_o (ready[Cells]),
    .stage_i (stage[Cells]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .pixel_o (out_pixel_o)
  );

  // Conditions used by the checks below.
  assign out_black    = (out_pixel_o.brightness == 8'd0);
  assign out_sat_zero = (out_pixel_o.saturation == 8'd0);
  assign out_hue_zero = (out_pixel_o.hue == 8'd0);

  // A black pixel gives an all-zero result.
  `RHP_ASSERT_IMP(a_black_zero, out_valid_o && out_black, out_hue_zero && out_sat_zero, "black pixel not all zero")

  // Zero saturation forces the hue to zero.
  `RHP_ASSERT_IMP(a_grey_hue, out_valid_o && out_sat_zero, out_hue_zero, "grey pixel with hue")

endmodule

`default_nettype wire
